/* hdl/uart_ring_buffer_pair_top_macros.svh */
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_top_macros.svh
// Assertion macros used by the UART ring buffer top level. They are written for
// the synchronous active-low reset and the clock of the top level.
// ----------------------------------------------------------------------------
`ifndef UART_RING_BUFFER_PAIR_TOP_MACROS_SVH
`define UART_RING_BUFFER_PAIR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold after the antecedent, later than in URBP_ASSERT_NEXT.
`define URBP_ASSERT_LATER(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

/* hdl/urbp_pkg.sv */
// ----------------------------------------------------------------------------
// urbp_pkg
// Types and constants shared by the UART ring buffer pair.
// ----------------------------------------------------------------------------
package urbp_pkg;

    localparam int BYTE_W       = 8;
    localparam int RX_DEPTH_DEF = 16;
    localparam int TX_DEPTH_DEF = 16;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_PUT      = 2'd1,
        OP_GET      = 2'd2,
        OP_TX_READY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT_LF,
        S_POP
    } t_state;

endpackage

/* hdl/urbp_ram.sv */
// ----------------------------------------------------------------------------
// urbp_ram
// Byte-wide simple dual-port memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module urbp_ram #(
    parameter int  DEPTH = urbp_pkg::RX_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [urbp_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [urbp_pkg::BYTE_W-1:0] o_rdata
);
    import urbp_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/uart_ring_buffer_pair_top.sv */
// A received byte, a put or an empty get/ready gives its item from the output registers in the cycle after acceptance;
// a get or ready event that pops a byte passes through the memory read register, then the output registers.
// Throughput: one item per cycle while the output is not stalled, except that a pop and a newline put
// hold off the next item for an extra state (S_POP for the registered memory read, S_PUT_LF for LF after CR).
// Reset clears the ring indexes, the send request and the output valid; the memories are
// not cleared, since an entry is only read after it was written.
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_top
// UART receive and transmit ring FIFOs held in two byte memories, with a
// small sequencer that reads, updates pointers and writes back per item.
// ----------------------------------------------------------------------------
`include "uart_ring_buffer_pair_top_macros.svh"

module uart_ring_buffer_pair_top #(
    parameter int RX_DEPTH = urbp_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbp_pkg::TX_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [urbp_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [urbp_pkg::BYTE_W-1:0] o_read_byte,
    output logic                        o_read_valid,
    output logic [urbp_pkg::BYTE_W-1:0] o_line_byte,
    output logic                        o_line_valid,
    output logic                        o_put_accepted,
    output logic                        o_rx_dropped,
    output logic                        o_rx_available,
    output logic                        o_send_request
);
    import urbp_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    t_state            r_state, n_state;
    logic [RX_AW-1:0]  r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [TX_AW-1:0]  r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic              r_send, n_send;
    logic [TX_AW-1:0]  r_lf_addr;
    logic              r_pop_rx, r_pend_avail, r_pend_send;

    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_read_byte, r_o_line_byte;
    logic              r_o_read_valid, r_o_line_valid, r_o_put_accepted;
    logic              r_o_rx_dropped, r_o_rx_available, r_o_send_request;

    t_opcode           w_op;
    logic              w_accept, w_pop, w_is_nl, w_put_ok, w_dropped;
    logic              rx_full, rx_empty, tx_full, tx_empty;
    logic [RX_AW-1:0]  rx_wr_inc, rx_rd_inc;
    logic [TX_AW-1:0]  tx_wr_inc, tx_wr_inc2, tx_rd_inc;

    logic              rx_we, rx_re, tx_we, tx_re;
    logic [TX_AW-1:0]  tx_waddr;
    logic [BYTE_W-1:0] tx_wdata, rx_q, tx_q;

    // ------------------------------------------------------------------
    // Ring pointer arithmetic and per-item decisions.
    // ------------------------------------------------------------------
    assign w_op       = t_opcode'(i_opcode);
    assign o_stall    = !((r_state == S_IDLE) && (!r_o_valid || !i_stall));
    assign w_accept   = i_valid && !o_stall;

    assign rx_wr_inc  = (r_rx_wr == RX_LAST) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_inc  = (r_rx_rd == RX_LAST) ? '0 : r_rx_rd + 1'b1;
    assign tx_wr_inc  = (r_tx_wr == TX_LAST) ? '0 : r_tx_wr + 1'b1;
    assign tx_wr_inc2 = (tx_wr_inc == TX_LAST) ? '0 : tx_wr_inc + 1'b1;
    assign tx_rd_inc  = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;

    assign rx_full    = (rx_wr_inc == r_rx_rd);
    assign rx_empty   = (r_rx_wr == r_rx_rd);
    assign tx_full    = (tx_wr_inc == r_tx_rd);
    assign tx_empty   = (r_tx_wr == r_tx_rd);

    // A newline expands to CR then LF and needs two free slots.
    assign w_is_nl    = (i_data_byte == CHAR_LF);
    assign w_put_ok   = w_is_nl ? (!tx_full && (tx_wr_inc2 != r_tx_rd)) : !tx_full;
    assign w_dropped  = (w_op == OP_RX_BYTE) && rx_full;
    assign w_pop      = ((w_op == OP_GET) && !rx_empty) || ((w_op == OP_TX_READY) && !tx_empty);

    always_comb begin
        n_rx_wr = r_rx_wr;
        n_rx_rd = r_rx_rd;
        n_tx_wr = r_tx_wr;
        n_tx_rd = r_tx_rd;
        n_send  = r_send;
        if (w_accept) begin
            unique case (w_op)
                OP_RX_BYTE: begin
                    if (!rx_full) begin
                        n_rx_wr = rx_wr_inc;
                    end
                end
                OP_PUT: begin
                    if (w_put_ok) begin
                        n_tx_wr = w_is_nl ? tx_wr_inc2 : tx_wr_inc;
                        n_send  = 1'b1;
                    end
                end
                OP_GET: begin
                    if (!rx_empty) begin
                        n_rx_rd = rx_rd_inc;
                    end
                end
                OP_TX_READY: begin
                    if (tx_empty) begin
                        n_send = 1'b0;
                    end else begin
                        n_tx_rd = tx_rd_inc;
                    end
                end
                default: begin
                    n_send = r_send;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_op == OP_PUT) && w_put_ok && w_is_nl) begin
                    n_state = S_PUT_LF;
                end else if (w_accept && w_pop) begin
                    n_state = S_POP;
                end
            end
            S_PUT_LF: n_state = S_IDLE;
            S_POP:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: memory port controls.
    // ------------------------------------------------------------------
    always_comb begin
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        tx_waddr = r_tx_wr;
        tx_wdata = i_data_byte;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_RX_BYTE:  rx_we = !rx_full;
                        OP_PUT: begin
                            tx_we    = w_put_ok;
                            tx_wdata = w_is_nl ? CHAR_CR : i_data_byte;
                        end
                        OP_GET:      rx_re = !rx_empty;
                        OP_TX_READY: tx_re = !tx_empty;
                        default:     rx_we = 1'b0;
                    endcase
                end
            end
            S_PUT_LF: begin
                tx_we    = 1'b1;
                tx_waddr = r_lf_addr;
                tx_wdata = CHAR_LF;
            end
            S_POP:   rx_we = 1'b0;
            default: rx_we = 1'b0;
        endcase
    end

    urbp_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (i_data_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_q)
    );

    urbp_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_re    (tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_q)
    );

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rx_wr   <= '0;
            r_rx_rd   <= '0;
            r_tx_wr   <= '0;
            r_tx_rd   <= '0;
            r_send    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rx_wr <= n_rx_wr;
            r_rx_rd <= n_rx_rd;
            r_tx_wr <= n_tx_wr;
            r_tx_rd <= n_tx_rd;
            r_send  <= n_send;
            if ((w_accept && !w_pop) || (r_state == S_POP)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers. A popping item parks its flags here until the
    // memory read data returns.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lf_addr    <= tx_wr_inc;
            r_pop_rx     <= (w_op == OP_GET);
            r_pend_avail <= (n_rx_wr != n_rx_rd);
            r_pend_send  <= n_send;
        end
        if (w_accept && !w_pop) begin
            r_o_read_byte    <= '0;
            r_o_read_valid   <= 1'b0;
            r_o_line_byte    <= '0;
            r_o_line_valid   <= 1'b0;
            r_o_put_accepted <= (w_op == OP_PUT) && w_put_ok;
            r_o_rx_dropped   <= w_dropped;
            r_o_rx_available <= (n_rx_wr != n_rx_rd);
            r_o_send_request <= n_send;
        end else if (r_state == S_POP) begin
            r_o_read_byte    <= r_pop_rx ? rx_q : '0;
            r_o_read_valid   <= r_pop_rx;
            r_o_line_byte    <= r_pop_rx ? '0 : tx_q;
            r_o_line_valid   <= !r_pop_rx;
            r_o_put_accepted <= 1'b0;
            r_o_rx_dropped   <= 1'b0;
            r_o_rx_available <= r_pend_avail;
            r_o_send_request <= r_pend_send;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_read_byte    = r_o_read_byte;
    assign o_read_valid   = r_o_read_valid;
    assign o_line_byte    = r_o_line_byte;
    assign o_line_valid   = r_o_line_valid;
    assign o_put_accepted = r_o_put_accepted;
    assign o_rx_dropped   = r_o_rx_dropped;
    assign o_rx_available = r_o_rx_available;
    assign o_send_request = r_o_send_request;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `URBP_ASSERT_NOW(a_single_pop, r_o_valid, !(r_o_read_valid && r_o_line_valid), "item pops both rings")
    `URBP_ASSERT_NOW(a_lf_slot, r_state == S_PUT_LF, (r_lf_addr == r_tx_wr - 1'b1) || ((r_tx_wr == '0) && (r_lf_addr == TX_LAST)), "LF slot does not trail the write index")
    `URBP_ASSERT_NOW(a_pop_read, r_state == S_POP, $past(rx_re || tx_re), "pop state without a memory read")
    `URBP_ASSERT_LATER(a_pop_result, w_accept && w_pop, r_o_valid, "popped byte did not reach the output")
    `URBP_ASSERT_NOW(a_idx_range, 1'b1, (32'(r_rx_wr) < RX_DEPTH) && (32'(r_tx_wr) < TX_DEPTH), "write index beyond ring depth")

endmodule

/* verif/uart_ring_buffer_pair_top_tb.sv */
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_top_tb
// Self-checking testbench for the UART receive/transmit ring buffer pair.
// A behavioral copy of both rings predicts the result of every accepted item.
// The stimulus runs in phases: directed corner cases, rings driven to full and
// empty, back-to-back traffic, and random bursts. In some phases both handshake
// sides idle at random.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urbp_pkg::*;

    localparam int RX_DEPTH     = RX_DEPTH_DEF;
    localparam int TX_DEPTH     = TX_DEPTH_DEF;
    localparam int RX_AW        = $clog2(RX_DEPTH);
    localparam int TX_AW        = $clog2(TX_DEPTH);
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 600_000;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] line_byte;
        logic              line_valid;
        logic              put_accepted;
        logic              rx_dropped;
        logic              rx_available;
        logic              send_request;
    } t_uart_result;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [1:0]        i_opcode    = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [BYTE_W-1:0] o_read_byte;
    logic              o_read_valid;
    logic [BYTE_W-1:0] o_line_byte;
    logic              o_line_valid;
    logic              o_put_accepted;
    logic              o_rx_dropped;
    logic              o_rx_available;
    logic              o_send_request;

    uart_ring_buffer_pair_top #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_byte    (o_read_byte),
        .o_read_valid   (o_read_valid),
        .o_line_byte    (o_line_byte),
        .o_line_valid   (o_line_valid),
        .o_put_accepted (o_put_accepted),
        .o_rx_dropped   (o_rx_dropped),
        .o_rx_available (o_rx_available),
        .o_send_request (o_send_request)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of both rings.
    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    int                rx_wr, rx_rd, tx_wr, tx_rd;
    logic              send_en;

    t_uart_result pending_results [$];
    int           errors;
    int           cycle_count;
    bit           gaps_on;
    bit           out_stall_on;
    int           out_stall_left;

    int n_items, n_rx_stored, n_rx_dropped, n_get_data, n_get_empty;
    int n_put_ok, n_put_rejected, n_newline_ok, n_line_bytes, n_ready_empty;

    function automatic int rx_next(int idx);
        return (idx + 1 >= RX_DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int tx_next(int idx);
        return (idx + 1 >= TX_DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic t_uart_result predict_uart_step(t_opcode op, logic [BYTE_W-1:0] d);
        t_uart_result r;
        int           need;
        int           room;
        r = '0;
        case (op)
            OP_RX_BYTE: begin
                if (rx_next(rx_wr) == rx_rd) begin
                    r.rx_dropped = 1'b1;
                    n_rx_dropped++;
                end else begin
                    rx_ring[RX_AW'(rx_wr)] = d;
                    rx_wr = rx_next(rx_wr);
                    n_rx_stored++;
                end
            end
            OP_PUT: begin
                need = (d == CHAR_LF) ? 2 : 1;
                room = (TX_DEPTH - 1) - ((tx_wr + TX_DEPTH - tx_rd) % TX_DEPTH);
                if (room >= need) begin
                    // A newline goes out on the line as CR followed by LF.
                    if (need == 2) begin
                        tx_ring[TX_AW'(tx_wr)] = CHAR_CR;
                        tx_wr = tx_next(tx_wr);
                        n_newline_ok++;
                    end
                    tx_ring[TX_AW'(tx_wr)] = d;
                    tx_wr = tx_next(tx_wr);
                    send_en = 1'b1;
                    r.put_accepted = 1'b1;
                    n_put_ok++;
                end else begin
                    n_put_rejected++;
                end
            end
            OP_GET: begin
                if (rx_wr != rx_rd) begin
                    r.read_byte  = rx_ring[RX_AW'(rx_rd)];
                    r.read_valid = 1'b1;
                    rx_rd = rx_next(rx_rd);
                    n_get_data++;
                end else begin
                    n_get_empty++;
                end
            end
            default: begin
                if (tx_wr == tx_rd) begin
                    send_en = 1'b0;
                    n_ready_empty++;
                end else begin
                    r.line_byte  = tx_ring[TX_AW'(tx_rd)];
                    r.line_valid = 1'b1;
                    tx_rd = tx_next(tx_rd);
                    n_line_bytes++;
                end
            end
        endcase
        r.rx_available = (rx_wr != rx_rd);
        r.send_request = send_en;
        return r;
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                        logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: mismatch on %s: expected 0x%02h, actual 0x%02h",
                     $realtime, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result checker and output-side stall generator.
    always @(posedge i_clk) begin
        t_uart_result exp_r;
        int           pick;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result arrived with nothing expected", $realtime);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("read_byte", exp_r.read_byte, o_read_byte);
                check_field("read_valid", BYTE_W'(exp_r.read_valid), BYTE_W'(o_read_valid));
                check_field("line_byte", exp_r.line_byte, o_line_byte);
                check_field("line_valid", BYTE_W'(exp_r.line_valid), BYTE_W'(o_line_valid));
                check_field("put_accepted", BYTE_W'(exp_r.put_accepted),
                            BYTE_W'(o_put_accepted));
                check_field("rx_dropped", BYTE_W'(exp_r.rx_dropped), BYTE_W'(o_rx_dropped));
                check_field("rx_available", BYTE_W'(exp_r.rx_available),
                            BYTE_W'(o_rx_available));
                check_field("send_request", BYTE_W'(exp_r.send_request),
                            BYTE_W'(o_send_request));
            end
        end
        if (!out_stall_on) begin
            out_stall_left = 0;
            i_stall <= 1'b0;
        end else if (out_stall_left > 0) begin
            out_stall_left--;
            i_stall <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                i_stall <= 1'b0;
            end else if (pick < 97) begin
                out_stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                out_stall_left = $urandom_range(19, 59);
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $realtime, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sends one item. Valid is left high on return so that the next item can
    // follow in the very next cycle; anything else must lower it first.
    task automatic send_item(t_opcode op, logic [BYTE_W-1:0] d);
        int gap;
        int pick;
        gap = 0;
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                gap = $urandom_range(8, 40);
            else if (pick >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_uart_step(op, d));
        n_items++;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        // Newlines are frequent so that the two-slot put case is hit often.
        return ($urandom_range(0, 7) == 0) ? CHAR_LF : BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic t_opcode pick_op(int mode);
        int p;
        p = $urandom_range(0, 99);
        case (mode)
            0: return (p < 70) ? OP_RX_BYTE : (p < 80) ? OP_PUT : (p < 95) ? OP_GET : OP_TX_READY;
            1: return (p < 15) ? OP_RX_BYTE : (p < 25) ? OP_PUT : (p < 90) ? OP_GET : OP_TX_READY;
            2: return (p < 10) ? OP_RX_BYTE : (p < 75) ? OP_PUT : (p < 85) ? OP_GET : OP_TX_READY;
            3: return (p < 10) ? OP_RX_BYTE : (p < 25) ? OP_PUT : (p < 35) ? OP_GET : OP_TX_READY;
            default: return (p < 25) ? OP_RX_BYTE : (p < 50) ? OP_PUT : (p < 75) ? OP_GET
                                                                          : OP_TX_READY;
        endcase
    endfunction

    task automatic test_directed();
        gaps_on      = 1'b0;
        out_stall_on = 1'b0;
        send_item(OP_GET, 8'h00);          // get with nothing received
        send_item(OP_TX_READY, 8'hFF);     // ready with nothing queued
        send_item(OP_RX_BYTE, 8'h00);
        send_item(OP_RX_BYTE, 8'hFF);
        send_item(OP_RX_BYTE, CHAR_LF);
        send_item(OP_GET, 8'hFF);
        send_item(OP_GET, 8'h00);
        send_item(OP_GET, 8'h5A);
        send_item(OP_GET, 8'hA5);
        send_item(OP_PUT, CHAR_LF);
        send_item(OP_PUT, CHAR_CR);
        send_item(OP_PUT, 8'hFF);
        send_item(OP_PUT, 8'h00);
        repeat (5) send_item(OP_TX_READY, 8'h00);
        send_item(OP_TX_READY, 8'h00);     // the empty ring clears the send request
        send_item(OP_PUT, 8'h55);
        send_item(OP_RX_BYTE, 8'hAA);
        send_item(OP_TX_READY, 8'hAA);
        send_item(OP_GET, 8'h55);
        send_item(OP_TX_READY, 8'h55);
    endtask

    task automatic test_rings_full();
        int k;
        gaps_on      = 1'b1;
        out_stall_on = 1'b1;
        // Overfill the receive ring, then drain it past empty.
        for (k = 0; k < RX_DEPTH + 1; k++)
            send_item(OP_RX_BYTE, BYTE_W'($urandom_range(0, 255)));
        for (k = 0; k < RX_DEPTH; k++)
            send_item(OP_GET, BYTE_W'($urandom_range(0, 255)));
        // Fill the transmit ring until puts are turned away.
        for (k = 0; k < TX_DEPTH + 4; k++)
            send_item(OP_PUT, pick_byte());
        // With a single free slot a newline must be refused but a plain byte fits.
        send_item(OP_TX_READY, 8'h00);
        send_item(OP_PUT, CHAR_LF);
        send_item(OP_PUT, 8'h7E);
        for (k = 0; k < TX_DEPTH + 1; k++)
            send_item(OP_TX_READY, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_bursts(int count);
        int sent;
        int burst_len;
        int mode;
        int k;
        sent = 0;
        while (sent < count) begin
            burst_len = $urandom_range(4, 40);
            mode      = $urandom_range(0, 4);
            for (k = 0; k < burst_len; k++)
                send_item(pick_op(mode), ($urandom_range(0, 1) == 0) ? pick_byte()
                                                     : BYTE_W'($urandom_range(0, 255)));
            sent += burst_len;
        end
    endtask

    task automatic test_back_to_back();
        gaps_on      = 1'b0;
        out_stall_on = 1'b0;
        run_bursts(300);
    endtask

    task automatic test_random_traffic();
        gaps_on      = 1'b1;
        out_stall_on = 1'b1;
        run_bursts(650);
        // Let all outstanding results drain before the second half.
        wait_results_drained();
        run_bursts(650);
    endtask

    initial begin
        rx_wr        = 0;
        rx_rd        = 0;
        tx_wr        = 0;
        tx_rd        = 0;
        send_en      = 1'b0;
        errors       = 0;
        cycle_count  = 0;
        gaps_on      = 1'b0;
        out_stall_on = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_results_drained();
        test_rings_full();
        wait_results_drained();
        test_back_to_back();
        wait_results_drained();
        test_random_traffic();
        wait_results_drained();

        $display("Ran %0d items: %0d bytes stored, %0d dropped, %0d gets with data, %0d empty",
                 n_items, n_rx_stored, n_rx_dropped, n_get_data, n_get_empty);
        $display("Puts %0d taken (%0d newlines), %0d refused; %0d bytes sent, %0d idle readies",
                 n_put_ok, n_newline_ok, n_put_rejected, n_line_bytes, n_ready_empty);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/urbp_pkg.sv
hdl/urbp_ram.sv
hdl/uart_ring_buffer_pair_top.sv
verif/uart_ring_buffer_pair_top_tb.sv
